// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the index and scale walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ndisw_pkg.sv
// Package with the types, codes and constants of the index and scale walker.
package ndisw_pkg;

    localparam int MAX_RANK_DEF     = 8;
    localparam int MAX_SPECTRUM_DEF = 4096;
    localparam int MAX_GRID_DEF     = 8192;
    localparam int INDEX_BITS_DEF   = 32;

    localparam logic signed [31:0] Q_ONE = 32'sd65536;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_RANK    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FORWARD = 1'd1;

    localparam logic [1:0] OP_SIZE   = 2'd0;
    localparam logic [1:0] OP_FACTOR = 2'd1;
    localparam logic [1:0] OP_STEP   = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         dim;
        logic [12:0]        spectrum_size;
        logic [13:0]        grid_size;
        logic               type_two;
        logic [11:0]        slot;
        logic signed [31:0] factor;
    } item_t;

    typedef struct packed {
        logic [31:0]        spectrum_index;
        logic [31:0]        grid_index;
        logic signed [31:0] scale;
        logic               is_source_spectrum;
        logic               last;
    } result_t;

    typedef struct packed {
        logic init;
        logic mul;
        logic rnd;
    } unit_ctl_t;

endpackage

// File: sv/ndisw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ndisw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/ndisw_unit.sv
// Shared multiplier unit: scale product with rounding and index accumulation.
module ndisw_unit #(
    parameter int IW  = 32,
    parameter int SW  = 13,
    parameter int GW  = 14,
    parameter int KW  = 12,
    parameter int GCW = 13
) (
    input  logic                  clk,
    input  ndisw_pkg::unit_ctl_t  ctl,
    input  logic signed [31:0]    factor,
    input  logic [SW-1:0]         ns,
    input  logic [GW-1:0]         ng,
    input  logic [KW-1:0]         ks,
    input  logic [GCW-1:0]        gc,
    output logic signed [31:0]    scale,
    output logic [IW-1:0]         sidx,
    output logic [IW-1:0]         gidx
);

    logic signed [63:0] prod_reg;
    logic signed [31:0] scale_reg;
    logic [IW-1:0]      sidx_reg;
    logic [IW-1:0]      gidx_reg;
    logic signed [63:0] rounded;
    logic signed [31:0] sat;

    always_comb
    begin
        rounded = (prod_reg + 64'sd32768) >>> 16;
        if (rounded > 64'sd2147483647)
        begin
            sat = 32'sh7FFFFFFF;
        end
        else if (rounded < -64'sd2147483648)
        begin
            sat = 32'sh80000000;
        end
        else
        begin
            sat = rounded[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            scale_reg <= ndisw_pkg::Q_ONE;
            sidx_reg  <= '0;
            gidx_reg  <= '0;
        end
        else if (ctl.mul)
        begin
            prod_reg <= 64'(scale_reg) * 64'(factor);
            sidx_reg <= IW'(sidx_reg * IW'(ns)) + IW'(ks);
            gidx_reg <= IW'(gidx_reg * IW'(ng)) + IW'(gc);
        end
        else if (ctl.rnd)
        begin
            scale_reg <= sat;
        end
    end

    assign scale = scale_reg;
    assign sidx  = sidx_reg;
    assign gidx  = gidx_reg;

endmodule

// File: sv/nd_deconv_index_scale_walker_top.sv
// Top level of the index and scale walker: sequencer, dimension state and output register.
// A step item passes through a multiply state and a rounding state for each dimension of the
// rank in use, then the output state, from which the result is registered on leaving.
// The next item is taken only after the output state, which waits while a result is held off.
// Size and factor items give no result and leave the sequencer idle.
// Reset clears control state and the dimension tables; the factor memory is not cleared.
module nd_deconv_index_scale_walker_top #(
    parameter int MAX_RANK     = ndisw_pkg::MAX_RANK_DEF,
    parameter int MAX_SPECTRUM = ndisw_pkg::MAX_SPECTRUM_DEF,
    parameter int MAX_GRID     = ndisw_pkg::MAX_GRID_DEF,
    parameter int INDEX_BITS   = ndisw_pkg::INDEX_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  ndisw_pkg::item_t                    item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output ndisw_pkg::result_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ndisw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ndisw_pkg::CFG_DATA_W-1:0]    cfg_data
);

`include "assert_macros.svh"

    localparam int RW    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int TW    = $clog2(MAX_RANK + 1);
    localparam int SW    = $clog2(MAX_SPECTRUM + 1);
    localparam int KW    = $clog2(MAX_SPECTRUM);
    localparam int GW    = $clog2(MAX_GRID + 1);
    localparam int GCW   = $clog2(MAX_GRID);
    localparam int DEPTH = MAX_RANK * MAX_SPECTRUM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_RND  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [TW-1:0] t_reg, t_next;
    logic [3:0]    rank_reg;
    logic          fwd_reg;

    logic [SW-1:0]  ns_reg [MAX_RANK];
    logic [SW-1:0]  ns_next [MAX_RANK];
    logic [GW-1:0]  ng_reg [MAX_RANK];
    logic [GW-1:0]  ng_next [MAX_RANK];
    logic [KW-1:0]  split_reg [MAX_RANK];
    logic [KW-1:0]  split_next [MAX_RANK];
    logic [KW-1:0]  plain_reg [MAX_RANK];
    logic [KW-1:0]  plain_next [MAX_RANK];
    logic [GCW-1:0] grid_reg [MAX_RANK];
    logic [GCW-1:0] grid_next [MAX_RANK];
    logic [KW-1:0]  slot_reg [MAX_RANK];
    logic [KW-1:0]  slot_next [MAX_RANK];

    ndisw_pkg::result_t result_reg;
    logic               result_valid_reg;

    logic [TW-1:0]  used_rank;
    logic [MAX_RANK-1:0] in_use, at_end, unset;
    logic           last_now;
    logic           accept, size_wr, factor_wr, step_go, rank_wr, fire, restart_now;
    logic [SW-1:0]  ns_sat;
    logic [GW-1:0]  ng_sat;
    logic [KW-1:0]  split_new;
    logic [TW-1:0]  rd_t;
    logic [RW-1:0]  rd_idx, cur_idx;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic signed [31:0] factor_rd;
    ndisw_pkg::unit_ctl_t ctl;
    logic signed [31:0] scale_w;
    logic [INDEX_BITS-1:0] sidx_w, gidx_w;

    always_comb
    begin
        if (rank_reg == '0)
        begin
            used_rank = TW'(1);
        end
        else if (int'(rank_reg) > MAX_RANK)
        begin
            used_rank = TW'(MAX_RANK);
        end
        else
        begin
            used_rank = TW'(rank_reg);
        end
        for (int t = 0; t < MAX_RANK; t++)
        begin
            in_use[t] = t < int'(used_rank);
            at_end[t] = plain_reg[t] == KW'(ns_reg[t] - SW'(1));
            unset[t]  = in_use[t] && (ns_reg[t] == '0);
        end
        last_now = &(at_end | ~in_use);
    end

    assign item_stall  = state_reg != ST_IDLE;
    assign cfg_ready   = 1'b1;
    assign accept      = item_valid && !item_stall;
    assign size_wr     = accept && (item.op == ndisw_pkg::OP_SIZE) && (int'(item.dim) < MAX_RANK);
    assign factor_wr   = accept && (item.op == ndisw_pkg::OP_FACTOR)
                         && (int'(item.dim) < MAX_RANK) && (int'(item.slot) < MAX_SPECTRUM);
    assign step_go     = accept && (item.op == ndisw_pkg::OP_STEP) && !(|unset);
    assign rank_wr     = cfg_valid && cfg_ready && (cfg_index == ndisw_pkg::REG_RANK);
    assign fire        = (state_reg == ST_OUT) && (!result_valid_reg || !result_stall);
    assign restart_now = rank_wr || size_wr || (fire && last_now);

    always_comb
    begin
        if (item.spectrum_size == '0)
        begin
            ns_sat = SW'(1);
        end
        else if (int'(item.spectrum_size) > MAX_SPECTRUM)
        begin
            ns_sat = SW'(MAX_SPECTRUM);
        end
        else
        begin
            ns_sat = SW'(item.spectrum_size);
        end
        if (int'(item.grid_size) > MAX_GRID)
        begin
            ng_sat = GW'(MAX_GRID);
        end
        else
        begin
            ng_sat = GW'(item.grid_size);
        end
        if (int'(ng_sat) < int'(ns_sat))
        begin
            ng_sat = GW'(ns_sat);
        end
        split_new = KW'(ns_sat >> 1);
        if (item.type_two && !ns_sat[0] && (split_new != '0))
        begin
            split_new = split_new - KW'(1);
        end
    end

    always_comb
    begin
        for (int t = 0; t < MAX_RANK; t++)
        begin
            ns_next[t]    = ns_reg[t];
            ng_next[t]    = ng_reg[t];
            split_next[t] = split_reg[t];
            if (size_wr && (int'(item.dim) == t))
            begin
                ns_next[t]    = ns_sat;
                ng_next[t]    = ng_sat;
                split_next[t] = split_new;
            end
        end
    end

    always_comb
    begin
        logic carry;
        logic [KW-1:0] p1;
        carry = 1'b1;
        p1    = '0;
        for (int t = 0; t < MAX_RANK; t++)
        begin
            plain_next[t] = plain_reg[t];
            grid_next[t]  = grid_reg[t];
            slot_next[t]  = slot_reg[t];
        end
        if (restart_now)
        begin
            for (int t = 0; t < MAX_RANK; t++)
            begin
                plain_next[t] = '0;
                grid_next[t]  = '0;
                slot_next[t]  = split_next[t];
            end
        end
        else if (fire)
        begin
            for (int t = MAX_RANK - 1; t >= 0; t--)
            begin
                if (in_use[t] && carry)
                begin
                    if ((t > 0) && at_end[t])
                    begin
                        plain_next[t] = '0;
                        grid_next[t]  = '0;
                        slot_next[t]  = split_reg[t];
                    end
                    else
                    begin
                        carry         = 1'b0;
                        p1            = plain_reg[t] + KW'(1);
                        plain_next[t] = p1;
                        grid_next[t]  = grid_reg[t] + GCW'(1);
                        slot_next[t]  = slot_reg[t] + KW'(1);
                        if (SW'(p1) == (ns_reg[t] - SW'(split_reg[t])))
                        begin
                            grid_next[t] = GCW'(ng_reg[t] - GW'(split_reg[t]));
                            slot_next[t] = '0;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (step_go)
                begin
                    ctl.init   = 1'b1;
                    t_next     = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                ctl.rnd = 1'b1;
                if ((t_reg + TW'(1)) < used_rank)
                begin
                    t_next     = t_reg + TW'(1);
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_t    = (state_reg == ST_IDLE) ? '0 : t_reg + TW'(1);
    assign rd_idx  = rd_t[RW-1:0];
    assign cur_idx = t_reg[RW-1:0];
    assign rd_addr = AW'(int'(rd_idx) * MAX_SPECTRUM + int'(slot_reg[rd_idx]));
    assign wr_addr = AW'(int'(item.dim) * MAX_SPECTRUM + int'(item.slot));

    ndisw_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_factor_ram (
        .clk     (clk),
        .wr_en   (factor_wr),
        .wr_addr (wr_addr),
        .wr_data (item.factor),
        .rd_en   (step_go || (ctl.rnd && (rd_t < used_rank))),
        .rd_addr (rd_addr),
        .rd_data (factor_rd)
    );

    ndisw_unit #(
        .IW  (INDEX_BITS),
        .SW  (SW),
        .GW  (GW),
        .KW  (KW),
        .GCW (GCW)
    ) u_unit (
        .clk    (clk),
        .ctl    (ctl),
        .factor (factor_rd),
        .ns     (ns_reg[cur_idx]),
        .ng     (ng_reg[cur_idx]),
        .ks     (slot_reg[cur_idx]),
        .gc     (grid_reg[cur_idx]),
        .scale  (scale_w),
        .sidx   (sidx_w),
        .gidx   (gidx_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            t_reg            <= '0;
            rank_reg         <= 4'd4;
            fwd_reg          <= 1'b1;
            result_valid_reg <= 1'b0;
            for (int t = 0; t < MAX_RANK; t++)
            begin
                ns_reg[t]    <= '0;
                ng_reg[t]    <= '0;
                split_reg[t] <= '0;
                plain_reg[t] <= '0;
                grid_reg[t]  <= '0;
                slot_reg[t]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
            if (rank_wr)
            begin
                rank_reg <= cfg_data;
            end
            if (cfg_valid && cfg_ready && (cfg_index == ndisw_pkg::REG_FORWARD))
            begin
                fwd_reg <= cfg_data[0];
            end
            if (fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            for (int t = 0; t < MAX_RANK; t++)
            begin
                ns_reg[t]    <= ns_next[t];
                ng_reg[t]    <= ng_next[t];
                split_reg[t] <= split_next[t];
                plain_reg[t] <= plain_next[t];
                grid_reg[t]  <= grid_next[t];
                slot_reg[t]  <= slot_next[t];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg.spectrum_index     <= 32'(sidx_w);
            result_reg.grid_index         <= 32'(gidx_w);
            result_reg.scale              <= scale_w;
            result_reg.is_source_spectrum <= fwd_reg;
            result_reg.last               <= last_now;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_NEXT(a_mul_then_rnd, state_reg == ST_MUL, state_reg == ST_RND,
        "A multiply cycle was not followed by a rounding cycle.")
    `ASSERT_NEXT(a_fire_gives_valid, fire, result_valid_reg,
        "A finished item did not reach the output register.")
    `ASSERT_SAME(a_dim_in_range, state_reg == ST_RND, t_reg < used_rank,
        "The dimension counter ran past the rank in use.")

endmodule
